// File: design/svptw_pkg.sv
// Shared types and constants for the Sv39 page table walker.
package svptw_pkg;

  localparam int TABLE_PAGES_DEF = 16;
  localparam int PTE_PER_PAGE    = 512;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PPN_W           = 44;
  localparam int PA_W            = 56;
  localparam int VA_W            = 39;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 4;

  // Input opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_USER   = 2'd1;
  localparam logic [1:0] OP_KERNEL = 2'd2;

  // Entry flag bit positions
  localparam int FLAG_V_BIT = 0;
  localparam int FLAG_U_BIT = 4;

  // Configuration register indexes (decoded from paddr[3])
  localparam logic REG_ROOT_PAGE = 1'b0;
  localparam logic REG_BASE_PPN  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_VA_HIGH      = 3'd1,
    ST_PTR_INVALID  = 3'd2,
    ST_LEAF_INVALID = 3'd3,
    ST_NOT_USER     = 3'd4,
    ST_OUTSIDE      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_RESULT = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic {
    WS_IDLE = 1'b0,
    WS_WALK = 1'b1
  } walk_state_e;

  // One classified item on its way from the front to the walker
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic        user;
    logic [37:0] va;
    logic [3:0]  wr_page;
    logic [8:0]  wr_index;
    logic [63:0] wr_value;
  } work_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } walk_stat_t;

endpackage

// File: design/svptw_front.sv
// Front part: classify incoming items before they enter the queue.
module svptw_front #(
  parameter int TABLE_PAGES = svptw_pkg::TABLE_PAGES_DEF
) (
  input  logic [1:0]          opcode_i,
  input  logic [38:0]         va_i,
  input  logic [3:0]          entry_page_i,
  input  logic [8:0]          entry_index_i,
  input  logic [63:0]         entry_value_i,
  input  logic [3:0]          root_page_i,
  output svptw_pkg::work_t    work_o
);
  import svptw_pkg::*;

  logic wr_inside;
  logic root_inside;

  assign wr_inside   = (32'(entry_page_i) < TABLE_PAGES);
  assign root_inside = (32'(root_page_i) < TABLE_PAGES);

  always_comb begin
    work_o          = '0;
    work_o.kind     = KIND_RESULT;
    work_o.status   = ST_OK;
    work_o.user     = (opcode_i == OP_USER);
    work_o.va       = va_i[37:0];
    work_o.wr_page  = entry_page_i;
    work_o.wr_index = entry_index_i;
    work_o.wr_value = entry_value_i;
    case (opcode_i)
      OP_WRITE: begin
        // drop writes that fall outside the store
        if (wr_inside) work_o.kind = KIND_WRITE;
      end
      OP_USER, OP_KERNEL: begin
        if (va_i[38]) begin
          work_o.status = ST_VA_HIGH;
        end else if (!root_inside) begin
          work_o.status = ST_OUTSIDE;
        end else begin
          work_o.kind = KIND_LOOKUP;
        end
      end
      default: begin
        work_o.kind = KIND_RESULT;
      end
    endcase
  end

endmodule

// File: design/svptw_queue.sv
// Short queue of classified items between the front and the walker.
module svptw_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  svptw_pkg::work_t       push_data_i,
  input  logic                   pop_i,
  output svptw_pkg::work_t       head_o,
  output svptw_pkg::queue_stat_t stat_o
);
  import svptw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: design/svptw_walker.sv
// Back part: entry store, three-level walk sequencer and result register.
module svptw_walker #(
  parameter int TABLE_PAGES = svptw_pkg::TABLE_PAGES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  svptw_pkg::work_t         head_i,
  input  logic                     head_valid_i,
  input  logic [3:0]               root_page_i,
  input  logic [43:0]              base_ppn_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output svptw_pkg::status_e       status_o,
  output logic [55:0]              phys_addr_o,
  output logic [9:0]               leaf_flags_o,
  output svptw_pkg::walk_stat_t    stat_o
);
  import svptw_pkg::*;

  localparam int PAGE_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int ADDR_W    = PAGE_W + 9;
  localparam int MEM_DEPTH = TABLE_PAGES * PTE_PER_PAGE;

  logic [63:0]        mem_q [MEM_DEPTH];
  logic [63:0]        rd_data_q;

  walk_state_e        state_q, state_d;
  logic [1:0]         level_q, level_d;
  logic               user_q;
  logic [37:0]        va_q;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [55:0]        out_pa_q;
  logic [9:0]         out_flags_q;

  logic               out_free;
  logic               pop;
  logic               load;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  status_e            res_status;
  logic [55:0]        res_pa;
  logic [9:0]         res_flags;

  logic [8:0]         root_ext;
  logic [8:0]         wr_page_ext;
  logic [43:0]        ppn;
  logic [43:0]        next_page;
  logic               next_outside;
  logic [8:0]         next_index;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign root_ext     = {5'b0, root_page_i};
  assign wr_page_ext  = {5'b0, head_i.wr_page};
  assign wr_addr      = {wr_page_ext[PAGE_W-1:0], head_i.wr_index};
  assign ppn          = rd_data_q[53:10];
  assign next_page    = ppn - base_ppn_i;
  assign next_outside = (next_page >= 44'(TABLE_PAGES));
  assign next_index   = (level_q == 2'd2) ? va_q[29:21] : va_q[20:12];

  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    res_status = ST_OK;
    res_pa     = '0;
    res_flags  = '0;
    state_d    = state_q;
    level_d    = level_q;
    case (state_q)
      WS_IDLE: begin
        if (head_valid_i && out_free) begin
          pop = 1'b1;
          case (head_i.kind)
            KIND_WRITE: begin
              wr_en = 1'b1;
              load  = 1'b1;
            end
            KIND_LOOKUP: begin
              rd_en   = 1'b1;
              rd_addr = {root_ext[PAGE_W-1:0], 1'b0, head_i.va[37:30]};
              state_d = WS_WALK;
              level_d = 2'd2;
            end
            default: begin
              load       = 1'b1;
              res_status = head_i.status;
            end
          endcase
        end
      end
      WS_WALK: begin
        if (level_q == 2'd0) begin
          // leaf level
          load      = 1'b1;
          res_flags = rd_data_q[9:0];
          state_d   = WS_IDLE;
          if (!rd_data_q[FLAG_V_BIT]) begin
            res_status = ST_LEAF_INVALID;
          end else if (user_q && !rd_data_q[FLAG_U_BIT]) begin
            res_status = ST_NOT_USER;
          end else if (user_q) begin
            res_pa = {ppn, 12'h000};
          end else begin
            res_pa = {ppn, va_q[11:0]};
          end
        end else if (!rd_data_q[FLAG_V_BIT]) begin
          load       = 1'b1;
          res_status = ST_PTR_INVALID;
          state_d    = WS_IDLE;
        end else if (next_outside) begin
          load       = 1'b1;
          res_status = ST_OUTSIDE;
          state_d    = WS_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {next_page[PAGE_W-1:0], next_index};
          level_d = level_q - 1'b1;
        end
      end
      default: begin
        state_d = WS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WS_IDLE;
      level_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      user_q <= head_i.user;
      va_q   <= head_i.va;
    end
    if (load) begin
      out_status_q <= res_status;
      out_pa_q     <= res_pa;
      out_flags_q  <= res_flags;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= head_i.wr_value;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign phys_addr_o  = out_pa_q;
  assign leaf_flags_o = out_flags_q;
  assign stat_o.pop   = pop;
  assign stat_o.busy  = (state_q == WS_WALK);

endmodule

// File: design/sv39_page_table_walk.sv
// Top level of the Sv39 page table walker: config registers, front, queue, walker.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------------------
//  in       input      in_valid_i / in_stall_o   opcode_i va_i entry_page_i entry_index_i
//                                                entry_value_i
//  out      output     out_valid_o / out_stall_i status_o phys_addr_o leaf_flags_o
//  cfg      input      psel penable pwrite       paddr pwdata (prdata on reads)
//
//  A write item or an item resolved by the front is finished as the walker pops it.
//  A lookup makes three dependent reads of the single-port entry store, each
//  registered in the read data register, followed by the leaf check.
//  Reset clears the control state and the config registers; the entry store keeps
//  no reset and holds garbage until written, so no clearing pass is run.
//  The two-entry queue keeps taking items while the walker works or the result
//  register stalls; in_stall_o rises only when the queue is full.
module sv39_page_table_walk #(
  parameter int TABLE_PAGES = svptw_pkg::TABLE_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic [svptw_pkg::VA_W-1:0]       va_i,
  input  logic [3:0]                       entry_page_i,
  input  logic [8:0]                       entry_index_i,
  input  logic [63:0]                      entry_value_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [svptw_pkg::PA_W-1:0]       phys_addr_o,
  output logic [9:0]                       leaf_flags_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [svptw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [svptw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [svptw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import svptw_pkg::*;

  logic [3:0]      root_page_q, root_page_d;
  logic [43:0]     base_ppn_q, base_ppn_d;
  logic            cfg_write;

  work_t           front_work;
  work_t           queue_head;
  queue_stat_t     q_stat;
  walk_stat_t      w_stat;
  status_e         walk_status;
  logic            in_xfer;

  // Configuration port: registers decoded on paddr[3], always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    root_page_d = root_page_q;
    base_ppn_d  = base_ppn_q;
    if (cfg_write) begin
      case (paddr[3])
        REG_ROOT_PAGE: root_page_d = pwdata[3:0];
        REG_BASE_PPN:  base_ppn_d  = pwdata[43:0];
        default:       root_page_d = root_page_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_page_q <= '0;
      base_ppn_q  <= '0;
    end else begin
      root_page_q <= root_page_d;
      base_ppn_q  <= base_ppn_d;
    end
  end

  assign prdata = (paddr[3] == REG_BASE_PPN) ? {20'b0, base_ppn_q} : {60'b0, root_page_q};

  // Input transfer: accepted whenever the queue has room.
  assign in_stall_o = q_stat.full;
  assign in_xfer    = in_valid_i && !in_stall_o;

  svptw_front #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_front (
    .opcode_i      (opcode_i),
    .va_i          (va_i),
    .entry_page_i  (entry_page_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .root_page_i   (root_page_q),
    .work_o        (front_work)
  );

  svptw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (front_work),
    .pop_i       (w_stat.pop),
    .head_o      (queue_head),
    .stat_o      (q_stat)
  );

  svptw_walker #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (queue_head),
    .head_valid_i (q_stat.valid),
    .root_page_i  (root_page_q),
    .base_ppn_i   (base_ppn_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (walk_status),
    .phys_addr_o  (phys_addr_o),
    .leaf_flags_o (leaf_flags_o),
    .stat_o       (w_stat)
  );

  assign status_o = walk_status;

  // The walker only takes an item when the result register is free or draining.
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_stat.pop |-> (!out_valid_o || !out_stall_i))
    else $error("walker took an item while the result register was blocked");

  // No result can sit in the output register while a walk is in progress.
  a_walk_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_stat.busy |-> !out_valid_o)
    else $error("result register held a result during a walk");

  // A fresh result comes only from a popped item or a finishing walk.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |->
      $past(w_stat.pop || w_stat.busy))
    else $error("result appeared without an item in the walker");

  // The walker never pops from an empty queue.
  a_pop_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_stat.pop |-> q_stat.valid)
    else $error("walker popped an empty queue");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the Sv39 page table walker: directed and random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svptw_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         TABLE_ENTRIES = TABLE_PAGES_DEF * PTE_PER_PAGE;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         PHASE_ITEMS   = 160;

  typedef struct packed {
    status_e         status;
    logic [PA_W-1:0] pa;
    logic [9:0]      flags;
  } walk_result_t;

  // Mirror of the entry store and config registers, plus the translations still owed.
  class translation_scoreboard;
    logic [63:0]      pte_mem [TABLE_ENTRIES];
    bit               pte_written [TABLE_ENTRIES];
    logic [3:0]       root_page;
    logic [PPN_W-1:0] base_ppn;
    walk_result_t     expected_translations [$];
    int unsigned      mismatches;

    function new();
      root_page  = '0;
      base_ppn   = '0;
      mismatches = 0;
    endfunction

    // Walk the three levels for one item; flag any read of a never-written entry.
    function void walk_tables(input logic [1:0] op, input logic [VA_W-1:0] va,
                              output walk_result_t res, output bit touches_unwritten);
      logic [PPN_W-1:0] pg;
      logic [PPN_W-1:0] ppn;
      logic [63:0]      pte;
      int               addr;
      int               lvl;
      bit               done;
      res = '{status: ST_OK, pa: '0, flags: '0};
      touches_unwritten = 1'b0;
      if (op == OP_USER || op == OP_KERNEL) begin
        if (va[VA_W-1]) begin
          res.status = ST_VA_HIGH;
        end else begin
          pg   = PPN_W'(root_page);
          lvl  = 2;
          done = 1'b0;
          while (!done) begin
            if (pg >= PPN_W'(TABLE_PAGES_DEF)) begin
              res.status = ST_OUTSIDE;
              done = 1'b1;
            end else begin
              addr = int'(pg) * PTE_PER_PAGE + int'(va[12 + 9 * lvl +: 9]);
              if (!pte_written[addr]) touches_unwritten = 1'b1;
              pte = pte_mem[addr];
              ppn = pte[53:10];
              if (lvl == 0) begin
                res.flags = pte[9:0];
                if (!pte[FLAG_V_BIT]) begin
                  res.status = ST_LEAF_INVALID;
                end else if (op == OP_USER && !pte[FLAG_U_BIT]) begin
                  res.status = ST_NOT_USER;
                end else begin
                  res.pa = {ppn, 12'h000};
                  if (op == OP_KERNEL) res.pa = res.pa + PA_W'(va[11:0]);
                end
                done = 1'b1;
              end else if (!pte[FLAG_V_BIT]) begin
                res.status = ST_PTR_INVALID;
                done = 1'b1;
              end else begin
                pg  = ppn - base_ppn;
                lvl = lvl - 1;
              end
            end
          end
        end
      end
    endfunction

    function bit lookup_safe(input logic [VA_W-1:0] va);
      walk_result_t res;
      bit           bad;
      walk_tables(OP_KERNEL, va, res, bad);
      return !bad;
    endfunction

    // Apply an accepted item to the store and queue the translation it must produce.
    function void note_transfer(input logic [1:0] op, input logic [VA_W-1:0] va,
                                input logic [3:0] page, input logic [8:0] index,
                                input logic [63:0] value);
      walk_result_t res;
      bit           bad;
      int           addr;
      if (op == OP_WRITE && int'(page) < TABLE_PAGES_DEF) begin
        addr = int'(page) * PTE_PER_PAGE + int'(index);
        pte_mem[addr]     = value;
        pte_written[addr] = 1'b1;
      end
      walk_tables(op, va, res, bad);
      expected_translations.push_back(res);
    endfunction

    function int pending();
      return expected_translations.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(input logic [2:0] status, input logic [PA_W-1:0] pa,
                      input logic [9:0] flags);
      walk_result_t want;
      if (expected_translations.size() == 0) begin
        report($sformatf("unexpected result status %0d pa %h flags %h", status, pa, flags));
      end else begin
        want = expected_translations.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, want %0d", status, want.status));
        if (pa !== want.pa)
          report($sformatf("phys_addr %h, want %h", pa, want.pa));
        if (flags !== want.flags)
          report($sformatf("leaf_flags %h, want %h", flags, want.flags));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i = OP_WRITE;
  logic [VA_W-1:0]   va_i = '0;
  logic [3:0]        entry_page_i = '0;
  logic [8:0]        entry_index_i = '0;
  logic [63:0]       entry_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        status_o;
  logic [PA_W-1:0]   phys_addr_o;
  logic [9:0]        leaf_flags_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic              pready;

  translation_scoreboard sb;

  int              burst_left = 0;
  int unsigned     items_sent = 0;
  logic [VA_W-1:0] mapped_vas [$];

  // receiver stall pattern state
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;
  bit stall_run  = 1'b0;

  sv39_page_table_walk dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .va_i          (va_i),
    .entry_page_i  (entry_page_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .phys_addr_o   (phys_addr_o),
    .leaf_flags_o  (leaf_flags_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: a correct run finishes far sooner than this.
  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

  // Result side: check every transfer against the oldest owed translation, then
  // pick the stall for the next cycle. Modes rotate between no stall, randomly
  // scattered stalls and long stall runs so gaps land on every walk phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, phys_addr_o, leaf_flags_o);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(32, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          stall_run = !stall_run;
          run_left  = stall_run ? $urandom_range(1, 16) : $urandom_range(1, 8);
        end
        run_left--;
        out_stall_i <= stall_run;
      end
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Valid pointer to a store page, with random reserved and permission bits.
  function automatic logic [63:0] pointer_to(input logic [3:0] page);
    logic [63:0] v;
    v = rand64();
    v[53:10] = sb.base_ppn + PPN_W'(page);
    v[FLAG_V_BIT] = 1'b1;
    return v;
  endfunction

  // Leaf with random address and flags, biased toward valid user pages.
  function automatic logic [63:0] leaf_entry();
    logic [63:0] v;
    v = rand64();
    v[FLAG_V_BIT] = ($urandom_range(0, 7) != 0);
    v[FLAG_U_BIT] = ($urandom_range(0, 2) != 0);
    return v;
  endfunction

  // Present one item and hold it until the transfer. Between bursts drop valid
  // for a random gap; some bursts are long with no gap at all.
  task automatic send_item(input logic [1:0] op, input logic [VA_W-1:0] va,
                           input logic [3:0] page, input logic [8:0] index,
                           input logic [63:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    va_i          <= va;
    entry_page_i  <= page;
    entry_index_i <= index;
    entry_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transfer(op, va, page, index, value);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_write(input logic [3:0] page, input logic [8:0] index,
                            input logic [63:0] value);
    send_item(OP_WRITE, VA_W'(rand64()), page, index, value);
  endtask

  // Never walk into an entry that was not written: fall back to a high address.
  task automatic send_lookup(input bit user, input logic [VA_W-1:0] va);
    logic [VA_W-1:0] addr;
    addr = va;
    if (!sb.lookup_safe(addr)) addr[VA_W-1] = 1'b1;
    send_item(user ? OP_USER : OP_KERNEL, addr, 4'($urandom), 9'($urandom), rand64());
  endtask

  // Drop valid and hold off until every owed translation has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write with setup and access cycles, then read the register back.
  task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (sel == REG_ROOT_PAGE) sb.root_page = value[3:0];
    else sb.base_ppn = value[PPN_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== value)
      sb.report($sformatf("register %0d reads %h, want %h", sel, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Directed pass with root page 0 and base 0: extremes of every field, every
  // opcode and every status, including a pointer with permission bits set.
  task automatic run_directed();
    send_item(OP_UNUSED, '1, 4'hF, 9'h1FF, '1);
    send_lookup(1'b1, 39'h40_0000_0000);
    send_lookup(1'b0, '1);
    send_write(4'd0, 9'd0, 64'h0000_0000_0000_0401);
    send_write(4'd1, 9'd0, 64'h0000_0000_0000_080F);
    send_write(4'd2, 9'd0, '1);
    send_lookup(1'b1, 39'h0);
    send_lookup(1'b0, 39'hFFF);
    send_write(4'd2, 9'd1, {10'h3FF, 44'h123_4567_89AB, 10'h001});
    send_lookup(1'b1, 39'h1000);
    send_lookup(1'b0, 39'h1ABC);
    send_write(4'd2, 9'd2, 64'h0000_0000_0000_03FE);
    send_lookup(1'b1, 39'h2000);
    send_write(4'd1, 9'd1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_lookup(1'b0, 39'h20_0000);
    send_write(4'd0, 9'd1, {10'h0, 44'd16, 10'h001});
    send_lookup(1'b1, 39'h4000_0000);
    send_write(4'd0, 9'h0FF, {10'h0, 44'd15, 10'h001});
    send_write(4'd15, 9'h1FF, {10'h0, 44'd3, 10'h001});
    send_write(4'd3, 9'h1FF, {10'h0, 44'hA_BCDE, 10'h011});
    send_lookup(1'b1, 39'h3F_FFFF_FFFF);
    send_lookup(1'b0, 39'h3F_FFFF_FFFF);
  endtask

  // Build a full three-level mapping, then translate through it.
  task automatic map_and_lookup(input bit leaf_valid);
    logic [8:0]      vpn2, vpn1, vpn0;
    logic [3:0]      p1, p0;
    logic [63:0]     leaf;
    logic [VA_W-1:0] va;
    int              n;
    vpn2 = {1'b0, 8'($urandom)};
    vpn1 = 9'($urandom);
    vpn0 = 9'($urandom);
    p1   = 4'($urandom);
    p0   = 4'($urandom);
    leaf = leaf_entry();
    if (!leaf_valid) leaf[FLAG_V_BIT] = 1'b0;
    send_write(sb.root_page, vpn2, pointer_to(p1));
    send_write(p1, vpn1, pointer_to(p0));
    send_write(p0, vpn0, leaf);
    va = {vpn2, vpn1, vpn0, 12'h000};
    if (mapped_vas.size() < 64) mapped_vas.push_back(va);
    else mapped_vas[$urandom_range(0, 63)] = va;
    n = $urandom_range(1, 3);
    repeat (n) send_lookup(1'($urandom_range(0, 1)), {va[VA_W-1:12], 12'($urandom)});
  endtask

  // Walks that stop early on invalid pointers or pointers leaving the store, or end on an invalid leaf.
  task automatic broken_walk();
    logic [8:0]       vpn2, vpn1;
    logic [3:0]       p1;
    logic [63:0]      v;
    logic [PPN_W-1:0] off;
    vpn2 = {1'b0, 8'($urandom)};
    vpn1 = 9'($urandom);
    p1   = 4'($urandom);
    v    = rand64();
    case ($urandom_range(0, 3))
      0: begin
        v[FLAG_V_BIT] = 1'b0;
        send_write(sb.root_page, vpn2, v);
      end
      1: begin
        off = PPN_W'(rand64());
        if (off < PPN_W'(TABLE_PAGES_DEF)) off = off + PPN_W'(TABLE_PAGES_DEF);
        v[53:10] = sb.base_ppn + off;
        v[FLAG_V_BIT] = 1'b1;
        send_write(sb.root_page, vpn2, v);
      end
      2: begin
        send_write(sb.root_page, vpn2, pointer_to(p1));
        send_write(p1, vpn1, v);
      end
      default: begin
        map_and_lookup(1'b0);
      end
    endcase
    send_lookup(1'($urandom_range(0, 1)), {vpn2, vpn1, 21'($urandom)});
  endtask

  task automatic noise_item();
    logic [VA_W-1:0] va;
    va = VA_W'(rand64());
    case ($urandom_range(0, 3))
      0: send_item(OP_UNUSED, va, 4'($urandom), 9'($urandom), rand64());
      1: send_write(4'($urandom), 9'($urandom), rand64());
      2: begin
        va[VA_W-1] = 1'b1;
        send_lookup(1'($urandom_range(0, 1)), va);
      end
      default: begin
        va[VA_W-1] = 1'b0;
        send_lookup(1'($urandom_range(0, 1)), va);
      end
    endcase
  endtask

  // Mostly well-formed mappings and revisits, the rest broken walks and noise.
  // Pause once midway until the walker has delivered everything.
  task automatic run_random(input int unsigned n);
    int unsigned     start;
    int              pick;
    bit              paused;
    logic [VA_W-1:0] va;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n) begin
      if (!paused && items_sent - start >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick < 70 && mapped_vas.size() == 0)) begin
        map_and_lookup(1'b1);
      end else if (pick < 70) begin
        va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
        send_lookup(1'($urandom_range(0, 1)), {va[VA_W-1:12], 12'($urandom)});
      end else if (pick < 82) begin
        broken_walk();
      end else begin
        noise_item();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_ROOT_PAGE, 64'd0);
    write_reg(REG_BASE_PPN, 64'd0);
    run_directed();

    // Each phase sets new registers while idle; the extremes of both come up.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_ROOT_PAGE, 64'd15);
          write_reg(REG_BASE_PPN, 64'h0FFF_FFFF_FFFF);
        end
        1: begin
          write_reg(REG_ROOT_PAGE, 64'($urandom_range(0, 15)));
          write_reg(REG_BASE_PPN, 64'(PPN_W'(rand64())));
        end
        2: begin
          write_reg(REG_ROOT_PAGE, 64'd0);
          write_reg(REG_BASE_PPN, 64'h0FFF_FFFF_FFF8);
        end
        default: begin
          write_reg(REG_ROOT_PAGE, 64'($urandom_range(0, 15)));
          write_reg(REG_BASE_PPN, 64'($urandom_range(0, 1000)));
        end
      endcase
      mapped_vas.delete();
      run_random(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/svptw_pkg.sv
design/svptw_front.sv
design/svptw_queue.sv
design/svptw_walker.sv
design/sv39_page_table_walk.sv
bench/tb.sv
